@@ rtl/pnef_pkg.sv @@
// Shared opcodes, status codes and unit flag type for the Petri net firing engine.
`default_nettype none
package pnef_pkg;

	localparam logic [2:0] OP_WR_IN  = 3'd0;
	localparam logic [2:0] OP_WR_OUT = 3'd1;
	localparam logic [2:0] OP_WR_TOK = 3'd2;
	localparam logic [2:0] OP_RD_TOK = 3'd3;
	localparam logic [2:0] OP_LIST   = 3'd4;
	localparam logic [2:0] OP_FIRE   = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic CFG_PLACES = 1'b0;
	localparam logic CFG_TRANS  = 1'b1;

	typedef struct packed {
		logic short_w;
		logic sat;
	} alu_flags_t;

endpackage
`default_nettype wire

@@ rtl/pnef_alu.sv @@
// Shared token unit: compare against input weight, subtract it, add output weight, saturate.
`default_nettype none
module pnef_alu #(
	parameter int TOKEN_BITS  = 16,
	parameter int WEIGHT_BITS = 8
) (
	input  wire logic [TOKEN_BITS-1:0]  tok,
	input  wire logic [WEIGHT_BITS-1:0] w_in,
	input  wire logic [WEIGHT_BITS-1:0] w_out,
	output logic [TOKEN_BITS-1:0]       next_tok,
	output pnef_pkg::alu_flags_t        flags
);

	localparam int AW = ((TOKEN_BITS > WEIGHT_BITS) ? TOKEN_BITS : WEIGHT_BITS) + 1;

	logic [AW-1:0] diff;
	logic [AW-1:0] sum;
	logic [AW-1:0] tok_max;

	always_comb begin
		tok_max       = AW'({TOKEN_BITS{1'b1}});
		diff          = AW'(tok) - AW'(w_in);
		sum           = AW'(diff[AW-2:0]) + AW'(w_out);
		flags.short_w = diff[AW-1];
		flags.sat     = (sum > tok_max);
		next_tok      = flags.sat ? {TOKEN_BITS{1'b1}} : sum[TOKEN_BITS-1:0];
	end

endmodule
`default_nettype wire

@@ rtl/petri_net_enable_and_fire.sv @@
// Top level of the Petri net engine: command sequencer, marking and arc weight stores.
`default_nettype none
// Commands are taken one at a time; in_ready is low while a command runs. Weight and token
// writes finish at the accepting edge. A token read passes through S_RD_TOK and S_EMIT to
// the output register. All place walks go through one registered read of the marking and
// weight stores and one shared compare/add unit, one place at a time over the places in
// use: a list checks each transition in use (stopping early when a place falls short) and
// emits each enabled transition but the last as the next one is found, then the last from
// S_LIST_END; a fire walks the places for the enable check, then again for the update.
// Results stall the walk only when the output register is still full.
// The marking has a valid bit per place, so no clearing pass follows reset.
module petri_net_enable_and_fire #(
	parameter int MAX_PLACES      = 32,
	parameter int MAX_TRANSITIONS = 32,
	parameter int TOKEN_BITS      = 16,
	parameter int WEIGHT_BITS     = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [4:0]  place_index,
	input  wire logic [4:0]  transition_index,
	input  wire logic [15:0] data_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       result_transition,
	output logic [15:0]      token_value,
	output logic             is_enabled,
	output logic [1:0]       status_code,
	output logic             last_result
);

	localparam int PW    = $clog2(MAX_PLACES);
	localparam int TW    = $clog2(MAX_TRANSITIONS);
	localparam int WAW   = PW + TW;
	localparam int WDEP  = 1 << WAW;
	localparam int CW    = 10;
	localparam int TCAP  = (MAX_TRANSITIONS < 32) ? MAX_TRANSITIONS : 32;
	localparam int XW0   = (TOKEN_BITS > WEIGHT_BITS) ? TOKEN_BITS : WEIGHT_BITS;
	localparam int XW    = (XW0 > 16) ? XW0 : 16;

	typedef enum logic [2:0] {
		S_IDLE, S_RD_TOK, S_EMIT, S_CHK_RD, S_CHK_CMP, S_LIST_END, S_UPD_RD, S_UPD_WR
	} state_t;

	state_t state_q;

	logic [5:0]             places_q;
	logic [5:0]             trans_q;
	logic [PW-1:0]          p_q;
	logic [TW-1:0]          tr_q;
	logic [4:0]             tin_q;
	logic                   pok_q;
	logic                   is_list_q;
	logic                   list_done_q;
	logic                   pend_v_q;
	logic [TW-1:0]          pend_t_q;
	logic                   sat_q;

	logic [4:0]             res_t_q;
	logic [15:0]            res_tok_q;
	logic                   res_en_q;
	logic [1:0]             res_st_q;
	logic                   res_last_q;

	logic                   out_valid_q;
	logic [4:0]             out_t_q;
	logic [15:0]            out_tok_q;
	logic                   out_en_q;
	logic [1:0]             out_st_q;
	logic                   out_last_q;

	logic [TOKEN_BITS-1:0]  mark_mem [MAX_PLACES];
	logic [MAX_PLACES-1:0]  mark_vld_q;
	logic [WEIGHT_BITS-1:0] win_mem  [WDEP];
	logic [WEIGHT_BITS-1:0] wout_mem [WDEP];

	logic [TOKEN_BITS-1:0]  mark_rd_q;
	logic                   vld_rd_q;
	logic [WEIGHT_BITS-1:0] win_rd_q;
	logic [WEIGHT_BITS-1:0] wout_rd_q;

	logic                   acc;
	logic                   can_emit;
	logic                   p_in_ok;
	logic                   t_in_ok;
	logic                   t_fire_ok;
	logic [PW-1:0]          last_p;
	logic [TW-1:0]          last_t;
	logic [WAW-1:0]         wt_wa;
	logic [WAW-1:0]         wt_ra;
	logic [PW-1:0]          mark_ra;
	logic [XW-1:0]          d_x;
	logic [XW-1:0]          wmax_x;
	logic [XW-1:0]          tmax_x;
	logic [WEIGHT_BITS-1:0] w_sat;
	logic [TOKEN_BITS-1:0]  d_tok_sat;
	logic                   tok_we;
	logic [PW-1:0]          tok_wa;
	logic [TOKEN_BITS-1:0]  tok_wd;
	logic [TOKEN_BITS-1:0]  alu_tok;
	logic [TOKEN_BITS-1:0]  alu_next;
	pnef_pkg::alu_flags_t   alu_flags;
	logic                   p_last;
	logic                   t_last;
	logic                   sat_now;

	always_comb begin
		acc      = in_valid && in_ready;
		can_emit = !out_valid_q || out_ready;
		p_in_ok  = CW'(place_index) < CW'(MAX_PLACES);
		t_in_ok  = CW'(transition_index) < CW'(MAX_TRANSITIONS);

		if (places_q == 6'd0)
			last_p = '0;
		else if (CW'(places_q) > CW'(MAX_PLACES))
			last_p = PW'(MAX_PLACES - 1);
		else
			last_p = PW'(places_q - 6'd1);

		if (trans_q == 6'd0)
			last_t = '0;
		else if (CW'(trans_q) > CW'(TCAP))
			last_t = TW'(TCAP - 1);
		else
			last_t = TW'(trans_q - 6'd1);

		t_fire_ok = t_in_ok && (CW'(transition_index) <= CW'(last_t));

		d_x       = XW'(data_value);
		wmax_x    = XW'({WEIGHT_BITS{1'b1}});
		tmax_x    = XW'({TOKEN_BITS{1'b1}});
		w_sat     = (d_x > wmax_x) ? {WEIGHT_BITS{1'b1}} : WEIGHT_BITS'(d_x);
		d_tok_sat = (d_x > tmax_x) ? {TOKEN_BITS{1'b1}} : TOKEN_BITS'(d_x);

		wt_wa = {TW'(transition_index), PW'(place_index)};
		wt_ra = {tr_q, p_q};

		// while idle the marking read follows the offered place so a token read is ready
		mark_ra = in_ready ? PW'(place_index) : p_q;

		if (state_q == S_UPD_WR) begin
			tok_we = 1'b1;
			tok_wa = p_q;
			tok_wd = alu_next;
		end else begin
			tok_we = acc && (opcode == pnef_pkg::OP_WR_TOK) && p_in_ok;
			tok_wa = PW'(place_index);
			tok_wd = d_tok_sat;
		end

		alu_tok = vld_rd_q ? mark_rd_q : '0;
		p_last  = (p_q == last_p);
		t_last  = (tr_q == last_t);
		sat_now = sat_q || alu_flags.sat;
	end

	pnef_alu #(
		.TOKEN_BITS  (TOKEN_BITS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_alu (
		.tok      (alu_tok),
		.w_in     (win_rd_q),
		.w_out    (wout_rd_q),
		.next_tok (alu_next),
		.flags    (alu_flags)
	);

	always_ff @(posedge clk) begin
		if (acc && (opcode == pnef_pkg::OP_WR_IN) && p_in_ok && t_in_ok)
			win_mem[wt_wa] <= w_sat;
		if (acc && (opcode == pnef_pkg::OP_WR_OUT) && p_in_ok && t_in_ok)
			wout_mem[wt_wa] <= w_sat;
		win_rd_q  <= win_mem[wt_ra];
		wout_rd_q <= wout_mem[wt_ra];
	end

	always_ff @(posedge clk) begin
		if (tok_we)
			mark_mem[tok_wa] <= tok_wd;
		mark_rd_q <= mark_mem[mark_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_vld_q <= '0;
			vld_rd_q   <= 1'b0;
		end else begin
			if (tok_we)
				mark_vld_q[tok_wa] <= 1'b1;
			vld_rd_q <= mark_vld_q[mark_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			places_q    <= 6'd32;
			trans_q     <= 6'd32;
			pend_v_q    <= 1'b0;
			list_done_q <= 1'b0;
			sat_q       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_EMIT))
				out_valid_q <= 1'b0;

			if (cfg_write) begin
				unique case (cfg_index)
					pnef_pkg::CFG_PLACES: places_q <= cfg_data;
					pnef_pkg::CFG_TRANS:  trans_q  <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						tin_q     <= transition_index;
						is_list_q <= (opcode == pnef_pkg::OP_LIST);
						unique case (opcode)
							pnef_pkg::OP_RD_TOK: begin
								p_q     <= PW'(place_index);
								pok_q   <= p_in_ok;
								state_q <= S_RD_TOK;
							end
							pnef_pkg::OP_LIST: begin
								tr_q        <= '0;
								p_q         <= '0;
								pend_v_q    <= 1'b0;
								list_done_q <= 1'b0;
								state_q     <= S_CHK_RD;
							end
							pnef_pkg::OP_FIRE: begin
								tr_q  <= TW'(transition_index);
								p_q   <= '0;
								sat_q <= 1'b0;
								if (t_fire_ok) begin
									state_q <= S_CHK_RD;
								end else begin
									res_t_q    <= transition_index;
									res_tok_q  <= '0;
									res_en_q   <= 1'b0;
									res_st_q   <= pnef_pkg::ST_NONE;
									res_last_q <= 1'b1;
									state_q    <= S_EMIT;
								end
							end
							default: ;
						endcase
					end
				end

				S_RD_TOK: begin
					res_t_q    <= '0;
					res_tok_q  <= (pok_q && vld_rd_q) ? 16'(mark_rd_q) : 16'd0;
					res_en_q   <= 1'b0;
					res_st_q   <= pnef_pkg::ST_OK;
					res_last_q <= 1'b1;
					state_q    <= S_EMIT;
				end

				S_EMIT: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						out_t_q     <= res_t_q;
						out_tok_q   <= res_tok_q;
						out_en_q    <= res_en_q;
						out_st_q    <= res_st_q;
						out_last_q  <= res_last_q;
						if (res_last_q)
							state_q <= S_IDLE;
						else if (list_done_q)
							state_q <= S_LIST_END;
						else
							state_q <= S_CHK_RD;
					end
				end

				S_CHK_RD: state_q <= S_CHK_CMP;

				S_CHK_CMP: begin
					if (alu_flags.short_w || p_last) begin
						if (is_list_q) begin
							if (t_last) begin
								list_done_q <= 1'b1;
							end else begin
								tr_q <= TW'(tr_q + 1'b1);
								p_q  <= '0;
							end
							if (!alu_flags.short_w && pend_v_q) begin
								res_t_q    <= 5'(pend_t_q);
								res_tok_q  <= '0;
								res_en_q   <= 1'b1;
								res_st_q   <= pnef_pkg::ST_OK;
								res_last_q <= 1'b0;
								pend_t_q   <= tr_q;
								state_q    <= S_EMIT;
							end else begin
								if (!alu_flags.short_w) begin
									pend_v_q <= 1'b1;
									pend_t_q <= tr_q;
								end
								state_q <= t_last ? S_LIST_END : S_CHK_RD;
							end
						end else if (alu_flags.short_w) begin
							res_t_q    <= tin_q;
							res_tok_q  <= '0;
							res_en_q   <= 1'b0;
							res_st_q   <= pnef_pkg::ST_NONE;
							res_last_q <= 1'b1;
							state_q    <= S_EMIT;
						end else begin
							p_q     <= '0;
							state_q <= S_UPD_RD;
						end
					end else begin
						p_q     <= PW'(p_q + 1'b1);
						state_q <= S_CHK_RD;
					end
				end

				S_LIST_END: begin
					res_tok_q  <= '0;
					res_last_q <= 1'b1;
					if (pend_v_q) begin
						res_t_q  <= 5'(pend_t_q);
						res_en_q <= 1'b1;
						res_st_q <= pnef_pkg::ST_OK;
					end else begin
						res_t_q  <= '0;
						res_en_q <= 1'b0;
						res_st_q <= pnef_pkg::ST_NONE;
					end
					state_q <= S_EMIT;
				end

				S_UPD_RD: state_q <= S_UPD_WR;

				S_UPD_WR: begin
					sat_q <= sat_now;
					if (p_last) begin
						res_t_q    <= tin_q;
						res_tok_q  <= '0;
						res_en_q   <= 1'b1;
						res_st_q   <= sat_now ? pnef_pkg::ST_SAT : pnef_pkg::ST_OK;
						res_last_q <= 1'b1;
						state_q    <= S_EMIT;
					end else begin
						p_q     <= PW'(p_q + 1'b1);
						state_q <= S_UPD_RD;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready          = (state_q == S_IDLE);
	assign out_valid         = out_valid_q;
	assign result_transition = out_t_q;
	assign token_value       = out_tok_q;
	assign is_enabled        = out_en_q;
	assign status_code       = out_st_q;
	assign last_result       = out_last_q;

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (opcode == pnef_pkg::OP_RD_TOK || opcode == pnef_pkg::OP_LIST ||
		 opcode == pnef_pkg::OP_FIRE)) |=> !in_ready)
		else $error("ready high right after a command that yields results");

	a_sat_implies_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_code == pnef_pkg::ST_SAT) |-> (is_enabled && last_result))
		else $error("saturation status on a beat that is not a successful fire");

	a_none_not_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_enabled && status_code == pnef_pkg::ST_NONE))
		else $error("enabled beat carries a not-enabled status");

	a_token_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_value != 16'd0) |-> (!is_enabled && status_code == pnef_pkg::ST_OK
		 && result_transition == 5'd0))
		else $error("token count on a list or fire beat");

	a_valid_bits_stick: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((mark_vld_q & $past(mark_vld_q)) == $past(mark_vld_q)))
		else $error("marking valid bit dropped");

endmodule
`default_nettype wire
